@@ rtl/vactrol_low_pass_gate_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Low pass gate assertion macros
// Shared assertion forms for the low pass gate checker.
// ---------------------------------------------------------------------------
`ifndef VACTROL_LOW_PASS_GATE_UNIT_MACROS_SVH
`define VACTROL_LOW_PASS_GATE_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LPG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LPG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lpg_pkg.sv @@
// ---------------------------------------------------------------------------
// Low pass gate package
// Widths, codes, control structs and the filter coefficient table.
// ---------------------------------------------------------------------------
package lpg_pkg;

    localparam int SAMPLE_RATE   = 48000;
    localparam int G_TABLE_DEPTH = 256;
    localparam int G_W           = 20;
    localparam int IDX_W         = (G_TABLE_DEPTH > 1) ? $clog2(G_TABLE_DEPTH) : 1;
    localparam int SPAN          = (G_TABLE_DEPTH > 1) ? G_TABLE_DEPTH - 1 : 1;

    localparam int ENV_W  = 31;
    localparam int ST_W   = 32;
    localparam int MA_W   = 34;
    localparam int MB_W   = 32;
    localparam int PROD_W = MA_W + MB_W;
    localparam int WIDE_W = PROD_W - 15;
    localparam int NUM_W  = 35;
    localparam int DVD_W  = MA_W + 16;
    localparam int DEN_W  = 25;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_W  = 16;

    localparam logic [ENV_W-1:0] ONE_Q30   = ENV_W'(32'h4000_0000);
    localparam logic [REG_W-1:0] K_MIN     = 16'd1638;
    localparam logic [REG_W-1:0] POINT3    = 16'd19661;

    localparam logic [REG_W-1:0] RST_AMOUNT    = 16'd65535;
    localparam logic [REG_W-1:0] RST_RELEASE   = 16'd65500;
    localparam logic [REG_W-1:0] RST_SLEW_UP   = 16'd2654;
    localparam logic [REG_W-1:0] RST_SLEW_DOWN = 16'd91;
    localparam logic [REG_W-1:0] RST_DAMPING   = 16'd32768;

    typedef enum logic [1:0] {
        FN_SAMPLE = 2'd0,
        FN_TRIG   = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        RG_AMOUNT    = 3'd0,
        RG_RELEASE   = 3'd1,
        RG_SLEW_UP   = 3'd2,
        RG_SLEW_DOWN = 3'd3,
        RG_DAMPING   = 3'd4
    } t_reg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TRIG0, ST_TRIG1,
        ST_DEC0, ST_DEC1, ST_DEC2, ST_DEC3, ST_DEC4,
        ST_SLEW0, ST_SLEW1,
        ST_LVL0, ST_LVL1, ST_LVL2,
        ST_FLT0, ST_FLT1, ST_FLT2, ST_FLT3,
        ST_DIV,
        ST_OUT0, ST_OUT1, ST_OUT2
    } t_state;

    typedef struct packed {
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
        logic            neg;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef logic [G_TABLE_DEPTH-1:0][G_W-1:0] t_g_rom;

    // Long division of non-negative operands, truncating. Only used while
    // the coefficient table is built.
    function automatic longint div_trunc(input longint a, input longint b);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int i = 62; i >= 0; i--) begin
            r = (r <<< 1) | ((a >>> i) & 64'sd1);
            if (r >= b) begin
                r = r - b;
                q = q | (64'sd1 <<< i);
            end
        end
        return q;
    endfunction

    // tan(x) by a 13-term series in Q30, returned in unsigned Q4.16.
    function automatic logic [G_W-1:0] tan_q16(input longint x);
        longint s;
        longint c;
        longint ts;
        longint tc;
        longint q;
        s  = x;
        c  = 64'sd1 <<< 30;
        ts = x;
        tc = 64'sd1 <<< 30;
        for (int n = 1; n <= 12; n++) begin
            ts = (((ts * x) >>> 30) * x) >>> 30;
            ts = div_trunc(ts, longint'((2 * n) * (2 * n + 1)));
            tc = (((tc * x) >>> 30) * x) >>> 30;
            tc = div_trunc(tc, longint'((2 * n - 1) * (2 * n)));
            if ((n & 1) != 0) begin
                s = s - ts;
                c = c - tc;
            end else begin
                s = s + ts;
                c = c + tc;
            end
        end
        if (s < 0) begin
            s = 0;
        end
        if (c <= 0) begin
            c = 1;
        end
        q = div_trunc((s <<< 16) + (c >>> 1), c);
        return q[G_W-1:0];
    endfunction

    // Cutoff runs from 40 Hz to 16 kHz over the table, angle capped at 1.5 rad.
    function automatic t_g_rom build_g_rom();
        t_g_rom rom;
        longint num;
        longint x;
        for (int i = 0; i < G_TABLE_DEPTH; i++) begin
            num = 64'sd40 * longint'(SPAN) + 64'sd15960 * longint'(i);
            x   = div_trunc(64'sd3373259426 * num,
                            longint'(SPAN) * longint'(SAMPLE_RATE));
            if (x > 64'sd1610612736) begin
                x = 64'sd1610612736;
            end
            rom[i] = tan_q16(x);
        end
        return rom;
    endfunction

    localparam t_g_rom G_ROM = build_g_rom();

endpackage

@@ rtl/lpg_mul.sv @@
// ---------------------------------------------------------------------------
// Low pass gate shared multiplier
// Registered sign-magnitude multiplier shared by the steps of the sequencer.
// ---------------------------------------------------------------------------
module lpg_mul (
    input  logic                        i_clk,
    input  lpg_pkg::t_mul_req           i_req,
    output logic [lpg_pkg::PROD_W-1:0]  o_prod,
    output logic                        o_neg
);
    import lpg_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic              r_neg;

    // Magnitudes are multiplied; the sign travels alongside so that the
    // consumer can shift the magnitude and truncate toward zero.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        r_neg  <= i_req.neg;
    end

    assign o_prod = r_prod;
    assign o_neg  = r_neg;

endmodule

@@ rtl/lpg_div.sv @@
// ---------------------------------------------------------------------------
// Low pass gate divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lpg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lpg_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [lpg_pkg::MA_W-1:0]  o_quot
);
    import lpg_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_nx;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        ge     = (rem_sh >= {1'b0, r_den});
        rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_rem <= rem_nx[DEN_W-1:0];
        end
    end

    // The quotient never exceeds the dividend's upper part, as the divisor
    // is at least 65536.
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_q[MA_W-1:0];

endmodule

@@ rtl/vactrol_low_pass_gate_unit.sv @@
// ---------------------------------------------------------------------------
// Vactrol low pass gate
// Envelope-driven state-variable low-pass filter and VCA in fixed point.
// ---------------------------------------------------------------------------
// A sample item runs through the decay, slew, lookup and filter steps and the
// 50 steps of the bit-serial divider before its result is valid; the next item
// is taken once the result is registered. Trigger, clear and unused-code items
// give no result.
// Reset (synchronous, active low) restores the register defaults and zeroes
// the envelope and filter state; the coefficient table is constant logic.
// ---------------------------------------------------------------------------
module vactrol_low_pass_gate_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [lpg_pkg::DATA_W-1:0]  pwdata,
    output logic [lpg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_func,
    input  logic signed [15:0]          i_sample_in,
    input  logic [15:0]                 i_velocity,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [15:0]          o_sample_out
);
    import lpg_pkg::*;

    // -----------------------------------------------------------------------
    // Configuration registers. Writes complete on the access cycle; reads are
    // combinational from the address.
    // -----------------------------------------------------------------------
    logic [REG_W-1:0] r_amount;
    logic [REG_W-1:0] r_release;
    logic [REG_W-1:0] r_slew_up;
    logic [REG_W-1:0] r_slew_down;
    logic [REG_W-1:0] r_damping;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount    <= RST_AMOUNT;
            r_release   <= RST_RELEASE;
            r_slew_up   <= RST_SLEW_UP;
            r_slew_down <= RST_SLEW_DOWN;
            r_damping   <= RST_DAMPING;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                RG_AMOUNT:    r_amount    <= pwdata[REG_W-1:0];
                RG_RELEASE:   r_release   <= pwdata[REG_W-1:0];
                RG_SLEW_UP:   r_slew_up   <= pwdata[REG_W-1:0];
                RG_SLEW_DOWN: r_slew_down <= pwdata[REG_W-1:0];
                RG_DAMPING:   r_damping   <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            RG_AMOUNT:    prdata = DATA_W'(r_amount);
            RG_RELEASE:   prdata = DATA_W'(r_release);
            RG_SLEW_UP:   prdata = DATA_W'(r_slew_up);
            RG_SLEW_DOWN: prdata = DATA_W'(r_slew_down);
            RG_DAMPING:   prdata = DATA_W'(r_damping);
            default:      prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Sequencer state and datapath registers. The envelope target and level
    // are unsigned Q1.30 held to 0..1; the filter states are signed Q2.30.
    // -----------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [ENV_W-1:0]        r_target, n_target;
    logic [ENV_W-1:0]        r_level, n_level;
    logic signed [ST_W-1:0]  r_band, n_band;
    logic signed [ST_W-1:0]  r_low, n_low;
    logic signed [15:0]      r_x, n_x;
    logic [15:0]             r_vel, n_vel;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0]        r_den, n_den;
    logic [G_W-1:0]          r_g, n_g;
    logic signed [15:0]      r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    // Shared multiplier and divider.
    t_mul_req          mul_req;
    logic [PROD_W-1:0] mul_prod;
    logic              mul_neg;
    t_div_req          div_req;
    logic              div_done;
    logic [MA_W-1:0]   div_quot;

    lpg_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod),
        .o_neg  (mul_neg)
    );

    lpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // The result register is free when it is empty or being taken now.
    logic out_free;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Signed 32-bit saturation of a wide sum.
    function automatic logic signed [ST_W-1:0] sat32(input logic signed [WIDE_W+1:0] v);
        logic signed [WIDE_W+1:0] hi;
        logic signed [WIDE_W+1:0] lo;
        hi = (WIDE_W+2)'(64'sh7FFF_FFFF);
        lo = -hi - 1;
        if (v > hi) begin
            return hi[ST_W-1:0];
        end else if (v < lo) begin
            return lo[ST_W-1:0];
        end
        return v[ST_W-1:0];
    endfunction

    // Product shifted down by 16 or by 14 with its sign restored (truncation toward 0).
    logic signed [WIDE_W-1:0] prod_sh16;
    logic signed [WIDE_W-1:0] prod_sh14;
    logic [REG_W-1:0]         k_eff;

    always_comb begin
        prod_sh16 = $signed({1'b0, mul_prod[PROD_W-1:16]});
        prod_sh14 = $signed({1'b0, mul_prod[PROD_W-3:14]});
        if (mul_neg) begin
            prod_sh16 = -prod_sh16;
            prod_sh14 = -prod_sh14;
        end
        // Damping below 0.1 is raised to 0.1.
        k_eff = (r_damping < K_MIN) ? K_MIN : r_damping;
    end

    // -----------------------------------------------------------------------
    // Next state. A sample runs decay, slew, table lookup, filter and VCA in
    // a fixed order; only the divider and the result register can hold it.
    // -----------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_func)
                        FN_SAMPLE: n_state = ST_DEC0;
                        FN_TRIG:   n_state = ST_TRIG0;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TRIG0: n_state = ST_TRIG1;
            ST_TRIG1: n_state = ST_IDLE;
            ST_DEC0:  n_state = ST_DEC1;
            ST_DEC1:  n_state = ST_DEC2;
            ST_DEC2:  n_state = ST_DEC3;
            ST_DEC3:  n_state = ST_DEC4;
            ST_DEC4:  n_state = ST_SLEW0;
            ST_SLEW0: n_state = ST_SLEW1;
            ST_SLEW1: n_state = ST_LVL0;
            ST_LVL0:  n_state = ST_LVL1;
            ST_LVL1:  n_state = ST_LVL2;
            ST_LVL2:  n_state = ST_FLT0;
            ST_FLT0:  n_state = ST_FLT1;
            ST_FLT1:  n_state = ST_FLT2;
            ST_FLT2:  n_state = ST_FLT3;
            ST_FLT3:  n_state = ST_DIV;
            ST_DIV:   n_state = div_done ? ST_OUT0 : ST_DIV;
            ST_OUT0:  n_state = ST_OUT1;
            ST_OUT1:  n_state = ST_OUT2;
            ST_OUT2:  n_state = out_free ? ST_IDLE : ST_OUT2;
            default:  n_state = ST_IDLE;
        endcase
    end

    // -----------------------------------------------------------------------
    // Datapath. Each step consumes the previous product and issues the next
    // multiplication to the shared unit.
    // -----------------------------------------------------------------------
    logic [ENV_W-1:0]         lsq;
    logic [ENV_W-1:0]         omr;
    logic [ENV_W-1:0]         adapt;
    logic [ENV_W:0]           t_dec;
    logic [ENV_W-1:0]         slew_mag;
    logic signed [ENV_W+1:0]  lvl_sum;
    logic [PROD_W:0]          idx_sum;
    logic [PROD_W-30:0]       idx_full;
    logic [IDX_W-1:0]         idx;
    logic signed [WIDE_W+1:0] num_w;
    logic signed [WIDE_W+1:0] st_sum;
    logic signed [ST_W-1:0]   st_sat;
    logic [NUM_W-1:0]         num_mag;
    logic signed [17:0]       y_w;

    always_comb begin
        n_target    = r_target;
        n_level     = r_level;
        n_band      = r_band;
        n_low       = r_low;
        n_x         = r_x;
        n_vel       = r_vel;
        n_num       = r_num;
        n_den       = r_den;
        n_g         = r_g;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mul_req     = '0;
        div_req     = '0;
        lsq         = mul_prod[30 +: ENV_W];
        omr         = ENV_W'({17'h10000 - {1'b0, r_release}, 14'b0});
        adapt       = ENV_W'({r_release, 14'b0}) + mul_prod[16 +: ENV_W];
        t_dec       = mul_prod[30 +: ENV_W+1];
        slew_mag    = mul_prod[16 +: ENV_W];
        lvl_sum     = '0;
        idx_sum     = {1'b0, mul_prod} + ((PROD_W+1)'(1) << 29);
        idx_full    = idx_sum[PROD_W:30];
        idx         = (idx_full > (PROD_W-29)'(G_TABLE_DEPTH - 1)) ?
                      IDX_W'(G_TABLE_DEPTH - 1) : idx_full[IDX_W-1:0];
        num_w       = '0;
        st_sum      = '0;
        st_sat      = '0;
        num_mag     = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
        y_w         = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_x   = i_sample_in;
                    n_vel = i_velocity;
                    if (i_func == FN_CLEAR) begin
                        n_target = '0;
                        n_level  = '0;
                        n_band   = '0;
                        n_low    = '0;
                    end
                end
            end
            ST_TRIG0: begin
                mul_req.a = MA_W'(r_vel);
                mul_req.b = MB_W'(r_amount);
            end
            ST_TRIG1: begin
                // velocity * amount is Q0.32; down by two gives Q1.30.
                n_target = mul_prod[2 +: ENV_W];
                n_level  = mul_prod[2 +: ENV_W];
            end
            // Release factor shrinks as the target grows: r + 0.3 (1-r)(1-t^2).
            ST_DEC0: begin
                mul_req.a = MA_W'(r_target);
                mul_req.b = MB_W'(r_target);
            end
            ST_DEC1: begin
                mul_req.a = MA_W'(omr);
                mul_req.b = MB_W'(ONE_Q30 - lsq);
            end
            ST_DEC2: begin
                mul_req.a = MA_W'(lsq);
                mul_req.b = MB_W'(POINT3);
            end
            ST_DEC3: begin
                mul_req.a = MA_W'(adapt);
                mul_req.b = MB_W'(r_target);
            end
            ST_DEC4: begin
                n_target = (t_dec > {1'b0, ONE_Q30}) ? ONE_Q30 : t_dec[ENV_W-1:0];
            end
            // The level follows the target, quickly upward and slowly down.
            ST_SLEW0: begin
                if (r_target > r_level) begin
                    mul_req.a   = MA_W'(r_target - r_level);
                    mul_req.b   = MB_W'(r_slew_up);
                    mul_req.neg = 1'b0;
                end else begin
                    mul_req.a   = MA_W'(r_level - r_target);
                    mul_req.b   = MB_W'(r_slew_down);
                    mul_req.neg = 1'b1;
                end
            end
            ST_SLEW1: begin
                lvl_sum = mul_neg ?
                          ($signed({2'b0, r_level}) - $signed({2'b0, slew_mag})) :
                          ($signed({2'b0, r_level}) + $signed({2'b0, slew_mag}));
                if (lvl_sum < 0) begin
                    n_level = '0;
                end else if (lvl_sum > $signed({2'b0, ONE_Q30})) begin
                    n_level = ONE_Q30;
                end else begin
                    n_level = lvl_sum[ENV_W-1:0];
                end
            end
            // The table is indexed by level squared, rounded to nearest.
            ST_LVL0: begin
                mul_req.a = MA_W'(r_level);
                mul_req.b = MB_W'(r_level);
            end
            ST_LVL1: begin
                mul_req.a = MA_W'(lsq);
                mul_req.b = MB_W'(SPAN);
            end
            ST_LVL2: begin
                n_g = G_ROM[idx];
            end
            // One step of the state-variable filter:
            // hp = (x - lp - k*bp) / (1 + k*g + g^2).
            ST_FLT0: begin
                mul_req.a   = MA_W'($unsigned(r_band[ST_W-1] ? -r_band : r_band));
                mul_req.b   = MB_W'(k_eff);
                mul_req.neg = r_band[ST_W-1];
            end
            ST_FLT1: begin
                num_w = (WIDE_W+2)'($signed({r_x, 15'b0}))
                      - (WIDE_W+2)'(r_low)
                      - (WIDE_W+2)'(prod_sh14);
                n_num     = num_w[NUM_W-1:0];
                mul_req.a = MA_W'(k_eff);
                mul_req.b = MB_W'(r_g);
            end
            ST_FLT2: begin
                n_den     = DEN_W'(32'h10000) + mul_prod[14 +: DEN_W];
                mul_req.a = MA_W'(r_g);
                mul_req.b = MB_W'(r_g);
            end
            ST_FLT3: begin
                div_req.start    = 1'b1;
                div_req.dividend = {num_mag[MA_W-1:0], 16'b0};
                div_req.divisor  = r_den + mul_prod[16 +: DEN_W];
            end
            ST_DIV: begin
                mul_req.a   = div_quot;
                mul_req.b   = MB_W'(r_g);
                mul_req.neg = r_num[NUM_W-1];
            end
            ST_OUT0: begin
                st_sum      = (WIDE_W+2)'(r_band) + (WIDE_W+2)'(prod_sh16);
                st_sat      = sat32(st_sum);
                n_band      = st_sat;
                mul_req.a   = MA_W'($unsigned(st_sat[ST_W-1] ? -st_sat : st_sat));
                mul_req.b   = MB_W'(r_g);
                mul_req.neg = st_sat[ST_W-1];
            end
            ST_OUT1: begin
                st_sum      = (WIDE_W+2)'(r_low) + (WIDE_W+2)'(prod_sh16);
                st_sat      = sat32(st_sum);
                n_low       = st_sat;
                mul_req.a   = MA_W'($unsigned(st_sat[ST_W-1] ? -st_sat : st_sat));
                mul_req.b   = MB_W'(r_level);
                mul_req.neg = st_sat[ST_W-1];
            end
            // VCA: low-pass times level, back to Q1.15 and saturated. The
            // product is issued again every cycle so that it is still there
            // when a stalled result register frees up.
            ST_OUT2: begin
                mul_req.a   = MA_W'($unsigned(r_low[ST_W-1] ? -r_low : r_low));
                mul_req.b   = MB_W'(r_level);
                mul_req.neg = r_low[ST_W-1];
                y_w = $signed({1'b0, mul_prod[45 +: 17]});
                if (mul_neg) begin
                    y_w = -y_w;
                end
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (y_w > 18'sd32767) begin
                        n_out = 16'sh7FFF;
                    end else if (y_w < -18'sd32768) begin
                        n_out = -16'sh8000;
                    end else begin
                        n_out = y_w[15:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_target    <= '0;
            r_level     <= '0;
            r_band      <= '0;
            r_low       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_target    <= n_target;
            r_level     <= n_level;
            r_band      <= n_band;
            r_low       <= n_low;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_vel <= n_vel;
        r_num <= n_num;
        r_den <= n_den;
        r_g   <= n_g;
        r_out <= n_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule

@@ rtl/lpg_checker.sv @@
// ---------------------------------------------------------------------------
// Low pass gate checker
// Port-level assertions on item flow, bound to the low pass gate.
// ---------------------------------------------------------------------------
`include "vactrol_low_pass_gate_unit_macros.svh"

module lpg_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [1:0]        i_func,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic signed [15:0] o_sample_out
);
    import lpg_pkg::*;

    // Once a sample item is accepted, the block reports itself busy.
    `LPG_ASSERT(a_sample_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall && i_func == FN_SAMPLE) |=> o_in_stall, "sample item did not occupy the block")

    // Trigger, clear and unused items never produce a result.
    `LPG_ASSERT(a_no_result, i_clk, i_rst_n, (i_in_valid && !o_in_stall && i_func != FN_SAMPLE && !o_out_valid) |=> !o_out_valid, "result appeared for a non-sample item")

    // A stalled result stays put.
    `LPG_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_out)), "stalled result changed")

    // Reset empties the result register.
    `LPG_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind vactrol_low_pass_gate_unit lpg_checker u_lpg_checker (.*);
